@@ src/tbl_pkg.sv @@
// Shared types, constants and helpers for the token bucket limiter.
// No dependencies; every other file except tbl_ram imports this package.
package tbl_pkg;

    localparam int NUM_BUCKETS = 64;
    localparam int FRAC_BITS   = 16;
    localparam int ADDR_W      = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int LVL_W       = 32;
    localparam int TICK_W      = 32;
    localparam int REQ_W       = 16;
    localparam int DIV_W       = REQ_W + FRAC_BITS;
    localparam int CNT_W       = $clog2(DIV_W);
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [15:0] RATE_LIMIT_RST = 16'd100;
    localparam logic [15:0] BURST_RST      = 16'd100;
    localparam logic [31:0] REFILL_RST     = 32'd65536;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_CONSUME = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        REG_RATE_LIMIT = 2'd0,
        REG_BURST_SIZE = 2'd1,
        REG_REFILL     = 2'd2
    } t_reg;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [5:0]       bucket_index;
        logic [REQ_W-1:0] tokens_requested;
    } t_item;

    typedef struct packed {
        logic        allowed;
        logic [15:0] remaining;
        logic [31:0] retry_after;
    } t_result;

    typedef struct packed {
        logic [ADDR_W-1:0] idx;
        logic [REQ_W-1:0]  req;
        logic              fresh;
        logic [TICK_W-1:0] now;
    } t_job;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_REFILL,
        S_DECIDE,
        S_DIV
    } t_state;

    // whole tokens to fixed point, held below 2^32
    function automatic logic [LVL_W-1:0] to_fixed(input logic [15:0] whole);
        logic [63:0] v;
        v = 64'(whole) << FRAC_BITS;
        return (v > 64'hFFFF_FFFF) ? '1 : v[LVL_W-1:0];
    endfunction

endpackage

@@ src/tbl_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module tbl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                       i_wdata,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/tbl_front.sv @@
// Front end: accepts words, keeps the tick counter and bucket valid bits,
// and queues consume jobs for the back end. Depends on tbl_pkg.
module tbl_front import tbl_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_item i_item,
    input  logic  i_full,
    output logic  o_busy,
    output logic  o_push,
    output t_job  o_job
);
    logic [TICK_W-1:0]      r_now, n_now;
    logic [NUM_BUCKETS-1:0] r_valid, n_valid;
    logic                   accept;
    logic                   in_range;
    logic [ADDR_W-1:0]      idx;

    assign accept   = i_start && !i_full;
    assign o_busy   = i_full;
    assign in_range = 32'(i_item.bucket_index) < 32'(NUM_BUCKETS);
    assign idx      = ADDR_W'(i_item.bucket_index);

    always_comb begin
        n_now   = r_now;
        n_valid = r_valid;
        o_push  = 1'b0;
        if (accept) begin
            case (t_cmd'(i_item.cmd))
                CMD_TICK:    n_now = r_now + 1'b1;
                CMD_CONSUME: begin
                    if (in_range) begin
                        n_valid[idx] = 1'b1;
                        o_push       = 1'b1;
                    end
                end
                CMD_CLEAR: begin
                    if (in_range) begin
                        n_valid[idx] = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_job.idx   = idx;
    assign o_job.req   = i_item.tokens_requested;
    assign o_job.fresh = !r_valid[idx];
    assign o_job.now   = r_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now   <= '0;
            r_valid <= '0;
        end else begin
            r_now   <= n_now;
            r_valid <= n_valid;
        end
    end
endmodule

@@ src/tbl_queue.sv @@
// Short job queue between front and back end.
// Depends on tbl_pkg.
module tbl_queue import tbl_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_job
);
    t_job              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = r_cnt == QCNT_W'(QDEPTH);
    assign o_empty = r_cnt == '0;
    assign o_job   = r_slot[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end
endmodule

@@ src/tbl_back.sv @@
// Back end: bucket memory, refill, grant decision and iterative retry divide.
// Depends on tbl_pkg and tbl_ram.
module tbl_back import tbl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_empty,
    input  t_job        i_job,
    output logic        o_pop,
    output logic        o_strobe,
    output t_result     o_result
);
    t_state             r_state, n_state;
    logic [15:0]        r_rate, r_burst;
    logic [31:0]        r_refill;
    t_job               r_job;
    logic [LVL_W-1:0]   r_lvl, r_new;
    logic [63:0]        r_prod;
    logic [DIV_W-1:0]   r_dvd, r_quot;
    logic [31:0]        r_rem;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_stb, n_stb;
    t_result            r_out, n_out;

    logic [63:0]        ram_q;
    logic               ram_we;
    logic [63:0]        ram_wd;
    logic [ADDR_W-1:0]  ram_addr;

    logic [LVL_W-1:0]   lvl0;
    logic [TICK_W-1:0]  stamp0, elapsed;
    logic [LVL_W-1:0]   cap;
    logic [64:0]        sum;
    logic [63:0]        req_fx;
    logic               grant;
    logic [LVL_W-1:0]   left;
    logic [32:0]        rem_sh;
    logic               ge;
    logic [32:0]        rem_n;
    logic [DIV_W-1:0]   quot_n;

    tbl_ram #(.WIDTH(64), .DEPTH(NUM_BUCKETS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wd),
        .o_rdata (ram_q)
    );

    // datapath terms
    assign lvl0    = r_job.fresh ? to_fixed(r_burst) : ram_q[LVL_W-1:0];
    assign stamp0  = r_job.fresh ? r_job.now : ram_q[63:32];
    assign elapsed = r_job.now - stamp0;
    assign cap     = to_fixed(r_rate);
    assign sum     = 65'(r_lvl) + 65'(r_prod);
    assign req_fx  = 64'(r_job.req) << FRAC_BITS;
    assign grant   = 64'(r_new) >= req_fx;
    assign left    = r_new - req_fx[LVL_W-1:0];
    assign rem_sh  = {r_rem, r_dvd[DIV_W-1]};
    assign ge      = rem_sh >= 33'(r_refill);
    assign rem_n   = ge ? rem_sh - 33'(r_refill) : rem_sh;
    assign quot_n  = {r_quot[DIV_W-2:0], ge};
    assign ram_addr = (r_state == S_IDLE) ? i_job.idx : r_job.idx;
    assign ram_wd   = {r_job.now, grant ? left : r_new};

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (!i_empty) n_state = S_MUL;
            S_MUL:    n_state = S_REFILL;
            S_REFILL: n_state = S_DECIDE;
            S_DECIDE: n_state = (grant || r_refill == '0) ? S_IDLE : S_DIV;
            S_DIV:    if (r_cnt == '0) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_pop  = 1'b0;
        ram_we = 1'b0;
        n_stb  = 1'b0;
        n_out  = '0;
        case (r_state)
            S_IDLE: o_pop = !i_empty;
            S_DECIDE: begin
                ram_we = 1'b1;
                if (grant) begin
                    n_stb           = 1'b1;
                    n_out.allowed   = 1'b1;
                    n_out.remaining = 16'(left >> FRAC_BITS);
                end else if (r_refill == '0) begin
                    n_stb             = 1'b1;
                    n_out.retry_after = '1;
                end
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    n_stb             = 1'b1;
                    n_out.retry_after = (64'(quot_n) > 64'hFFFF_FFFF) ? '1 : 32'(quot_n);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: r_job <= i_job;
            S_MUL: begin
                r_lvl  <= lvl0;
                r_prod <= 64'(elapsed) * 64'(r_refill);
            end
            S_REFILL: begin
                r_new <= (r_prod >= 64'(cap) || sum >= 65'(cap)) ? cap : sum[LVL_W-1:0];
            end
            S_DECIDE: begin
                r_dvd  <= DIV_W'(req_fx - 64'(r_new));
                r_quot <= '0;
                r_rem  <= '0;
                r_cnt  <= CNT_W'(DIV_W - 1);
            end
            S_DIV: begin
                r_dvd  <= r_dvd << 1;
                r_quot <= quot_n;
                r_rem  <= rem_n[31:0];
                r_cnt  <= r_cnt - 1'b1;
            end
            default: ;
        endcase
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_stb    <= 1'b0;
            r_rate   <= RATE_LIMIT_RST;
            r_burst  <= BURST_RST;
            r_refill <= REFILL_RST;
        end else begin
            r_state <= n_state;
            r_stb   <= n_stb;
            if (i_cfg_we) begin
                case (t_reg'(i_cfg_idx))
                    REG_RATE_LIMIT: r_rate   <= i_cfg_data[15:0];
                    REG_BURST_SIZE: r_burst  <= i_cfg_data[15:0];
                    REG_REFILL:     r_refill <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign o_strobe = r_stb;
    assign o_result = r_out;
endmodule

@@ src/token_bucket_limiter_unit.sv @@
// Token bucket limiter top level. An accepted consume waits in the queue, then
// passes back-end states MUL, REFILL and DECIDE before its word strobes; a denial
// with nonzero refill first runs the bit-serial retry divide. Ticks and clears
// give no word. Back end runs one job at a time behind a two-entry queue; busy rises
// only when that queue is full. Synchronous active-low reset clears tick counter,
// valid bits, queue and config to defaults; results cannot be stalled.
module token_bucket_limiter_unit import tbl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_item       i_item,
    output logic        o_strobe,
    output t_result     o_result,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    logic q_full, q_empty, q_push, q_pop;
    t_job front_job, head_job;

    tbl_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_item),
        .i_full  (q_full),
        .o_busy  (busy),
        .o_push  (q_push),
        .o_job   (front_job)
    );

    tbl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (head_job)
    );

    tbl_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_empty    (q_empty),
        .i_job      (head_job),
        .o_pop      (q_pop),
        .o_strobe   (o_strobe),
        .o_result   (o_result)
    );
endmodule

@@ src/tbl_checker.sv @@
// Port-level checks for the token bucket limiter, bound to the top level.
// Depends on tbl_pkg.
module tbl_checker import tbl_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_strobe,
    input t_result o_result
);
    // every word passes the back-end states MUL, REFILL and DECIDE
    a_no_adjacent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("back-to-back result words");

    a_grant_no_retry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.allowed) |-> o_result.retry_after == '0)
        else $error("grant with nonzero retry");

    a_deny_no_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.allowed) |-> o_result.remaining == '0)
        else $error("denial with remaining tokens");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_strobe)) else $error("activity after reset");

    a_busy_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(busy)) |-> $past(start)) else $error("busy without accepted word");
endmodule

bind token_bucket_limiter_unit tbl_checker u_tbl_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
